// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`define ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`define ASSERT_AFTER_RESET(label, clk, rst, cons, msg)

`endif

`endif

// ===== design/ddpi_pkg.sv =====
`timescale 1ns / 1ps

package ddpi_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int MODE_W   = 2;
  localparam int CAM_W    = 12;
  localparam int GAIN_W   = 16;
  localparam int FRONT_W  = 2;
  localparam int POS_W    = 12;
  localparam int CMD_W    = 3;
  localparam int SPD_W    = 10;
  localparam int MEAS_W   = 12;
  localparam int DUTY_W   = 16;
  localparam int STATUS_W = 2;

  localparam int ERR_W   = 13;
  localparam int PROD_W  = 30;
  localparam int INTEG_W = 32;
  localparam int SUM_W   = 34;

  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_WIDTH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KP           = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KI_LEFT      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KI_RIGHT     = 3'd4;

  localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WANDER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRACK  = 2'd2;

  localparam logic [CMD_W-1:0] CMD_FWD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FRONT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REAR  = 2'd2;

  localparam logic [MODE_W-1:0] RESET_MODE     = MODE_MANUAL;
  localparam logic [CAM_W-1:0]  RESET_CAM      = 12'd1335;
  localparam logic [GAIN_W-1:0] RESET_KP       = 16'd655;
  localparam logic [GAIN_W-1:0] RESET_KI_LEFT  = 16'd142;
  localparam logic [GAIN_W-1:0] RESET_KI_RIGHT = 16'd156;

  localparam logic [SPD_W-1:0] SPD_WANDER_FWD     = 10'd300;
  localparam logic [SPD_W-1:0] SPD_WANDER_TURN    = 10'd150;
  localparam logic [SPD_W-1:0] SPD_WANDER_BACKOFF = 10'd200;
  localparam logic [SPD_W-1:0] SPD_TRACK_FWD      = 10'd300;
  localparam logic [SPD_W-1:0] SPD_TRACK_TURN     = 10'd100;

  localparam logic [ERR_W-1:0] TRACK_WINDOW = 13'd120;
  localparam logic signed [SUM_W-1:0] DUTY_OFFSET = 34'sd100;
  localparam logic signed [SUM_W-1:0] ROUND_BIAS  = 34'sd65535;
  localparam int Q_SHIFT = 16;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [SPD_W-1:0]    spd;
    logic [STATUS_W-1:0] status;
  } decision_t;

  // Adds a step to an integral and saturates at the signed 32-bit bounds.
  function automatic logic signed [INTEG_W-1:0] integ_add(
    input logic signed [INTEG_W-1:0] integ,
    input logic signed [PROD_W-1:0]  step
  );
    logic signed [INTEG_W:0] sum;
    logic signed [INTEG_W-1:0] res;
    sum = (INTEG_W+1)'(integ) + (INTEG_W+1)'(step);
    if (sum[INTEG_W] != sum[INTEG_W-1]) begin
      res = sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      res = sum[INTEG_W-1:0];
    end
    return res;
  endfunction

  // Truncates (P + I) / 2^16 toward zero, adds the offset and saturates to 16 bits.
  function automatic logic signed [DUTY_W-1:0] duty_of(
    input logic signed [PROD_W-1:0]  p,
    input logic signed [INTEG_W-1:0] integ
  );
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] biased;
    logic signed [SUM_W-1:0] quot;
    logic signed [SUM_W-1:0] duty;
    logic signed [DUTY_W-1:0] res;
    sum    = SUM_W'(p) + SUM_W'(integ);
    biased = sum[SUM_W-1] ? sum + ROUND_BIAS : sum;
    quot   = biased >>> Q_SHIFT;
    duty   = quot + DUTY_OFFSET;
    if (duty > SUM_W'(32'sd32767)) begin
      res = {1'b0, {(DUTY_W-1){1'b1}}};
    end else if (duty < SUM_W'(-32'sd32768)) begin
      res = {1'b1, {(DUTY_W-1){1'b0}}};
    end else begin
      res = duty[DUTY_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== design/ddpi_if.sv =====
`timescale 1ns / 1ps

interface ddpi_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ddpi_pkg::FRONT_W-1:0]  front_obstacle;
  logic                                 rear_obstacle;
  logic [ddpi_pkg::POS_W-1:0]           target_x;
  logic [ddpi_pkg::POS_W-1:0]           target_y;
  logic [ddpi_pkg::CMD_W-1:0]           manual_command;
  logic [ddpi_pkg::SPD_W-1:0]           manual_speed;
  logic signed [ddpi_pkg::MEAS_W-1:0]   speed_left;
  logic signed [ddpi_pkg::MEAS_W-1:0]   speed_right;

  modport source (
    output valid, front_obstacle, rear_obstacle, target_x, target_y,
           manual_command, manual_speed, speed_left, speed_right,
    input  ready
  );
  modport sink (
    input  valid, front_obstacle, rear_obstacle, target_x, target_y,
           manual_command, manual_speed, speed_left, speed_right,
    output ready
  );
endinterface

interface ddpi_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ddpi_pkg::DUTY_W-1:0]   duty_left;
  logic signed [ddpi_pkg::DUTY_W-1:0]   duty_right;
  logic [ddpi_pkg::STATUS_W-1:0]        obstacle_status;
  logic [ddpi_pkg::CMD_W-1:0]           drive_command;
  logic [ddpi_pkg::SPD_W-1:0]           drive_speed;

  modport source (
    output valid, duty_left, duty_right, obstacle_status, drive_command, drive_speed,
    input  ready
  );
  modport sink (
    input  valid, duty_left, duty_right, obstacle_status, drive_command, drive_speed,
    output ready
  );
endinterface

// ===== design/diff_drive_mode_pi_speed_controller.sv =====
`timescale 1ns / 1ps
// A sample transfer passes through stage registers B, C and D and then the result register.
// Throughput: one sample per cycle while the result side is not stalled; the rate is
// set by the add-and-saturate loop that updates each wheel integral.
// Reset (synchronous, active high) restores the register defaults, clears both
// integrals and empties the pipeline.

`include "assert_macros.svh"

module diff_drive_mode_pi_speed_controller (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [ddpi_pkg::CFG_INDEX_W-1:0]      wr_index,
  input  logic [ddpi_pkg::CFG_DATA_W-1:0]       wr_data,
  ddpi_sample_if.sink                           sample,
  ddpi_result_if.source                         result
);

  logic [ddpi_pkg::MODE_W-1:0] drive_mode;
  logic [ddpi_pkg::CAM_W-1:0]  camera_width;
  logic [ddpi_pkg::GAIN_W-1:0] kp_q16;
  logic [ddpi_pkg::GAIN_W-1:0] ki_left_q16;
  logic [ddpi_pkg::GAIN_W-1:0] ki_right_q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode   <= ddpi_pkg::RESET_MODE;
      camera_width <= ddpi_pkg::RESET_CAM;
      kp_q16       <= ddpi_pkg::RESET_KP;
      ki_left_q16  <= ddpi_pkg::RESET_KI_LEFT;
      ki_right_q16 <= ddpi_pkg::RESET_KI_RIGHT;
    end else if (wr_en) begin
      unique case (wr_index)
        ddpi_pkg::REG_DRIVE_MODE:   drive_mode   <= wr_data[ddpi_pkg::MODE_W-1:0];
        ddpi_pkg::REG_CAMERA_WIDTH: camera_width <= wr_data[ddpi_pkg::CAM_W-1:0];
        ddpi_pkg::REG_KP:           kp_q16       <= wr_data[ddpi_pkg::GAIN_W-1:0];
        ddpi_pkg::REG_KI_LEFT:      ki_left_q16  <= wr_data[ddpi_pkg::GAIN_W-1:0];
        ddpi_pkg::REG_KI_RIGHT:     ki_right_q16 <= wr_data[ddpi_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: B holds the decision and errors, C the products,
  // D the updated integrals, and the result register the duties.
  logic valid_b, valid_c, valid_d;
  logic adv_b, adv_c, adv_d, adv_o;

  assign adv_o        = valid_d && (!result.valid || result.ready);
  assign adv_d        = valid_c && (!valid_d || adv_o);
  assign adv_c        = valid_b && (!valid_c || adv_d);
  assign sample.ready = !valid_b || adv_c;
  assign adv_b        = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b      <= 1'b0;
      valid_c      <= 1'b0;
      valid_d      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      valid_b      <= adv_b || (valid_b && !adv_c);
      valid_c      <= adv_c || (valid_c && !adv_d);
      valid_d      <= adv_d || (valid_d && !adv_o);
      result.valid <= adv_o || (result.valid && !result.ready);
    end
  end

  // Motion decision.
  ddpi_pkg::decision_t         dec;
  logic [ddpi_pkg::CMD_W-1:0]  mcmd;
  logic                        front_hit;
  logic                        front_left;
  logic [ddpi_pkg::ERR_W-1:0]  half;
  logic [ddpi_pkg::ERR_W-1:0]  tx_ext;
  logic                        no_target;
  logic                        in_window;

  always_comb begin
    mcmd       = (sample.manual_command > ddpi_pkg::CMD_STOP) ? ddpi_pkg::CMD_STOP
                                                              : sample.manual_command;
    front_hit  = !sample.front_obstacle[ddpi_pkg::FRONT_W-1];
    front_left = (sample.front_obstacle == '0);
    half       = ddpi_pkg::ERR_W'(camera_width >> 1);
    tx_ext     = ddpi_pkg::ERR_W'(sample.target_x);
    no_target  = (sample.target_x == '0) && (sample.target_y == '0);
    in_window  = (tx_ext + ddpi_pkg::TRACK_WINDOW > half) &&
                 (tx_ext < half + ddpi_pkg::TRACK_WINDOW);
    dec.cmd    = ddpi_pkg::CMD_STOP;
    dec.spd    = '0;
    dec.status = ddpi_pkg::STATUS_NONE;
    unique case (drive_mode)
      ddpi_pkg::MODE_MANUAL: begin
        if (front_hit) begin
          dec.status = ddpi_pkg::STATUS_FRONT;
        end else if (sample.rear_obstacle) begin
          dec.status = ddpi_pkg::STATUS_REAR;
        end else begin
          dec.cmd = mcmd;
          dec.spd = sample.manual_speed;
        end
      end
      ddpi_pkg::MODE_WANDER: begin
        if (front_hit) begin
          dec.cmd    = front_left ? ddpi_pkg::CMD_RIGHT : ddpi_pkg::CMD_LEFT;
          dec.spd    = ddpi_pkg::SPD_WANDER_TURN;
          dec.status = ddpi_pkg::STATUS_FRONT;
        end else if (sample.rear_obstacle) begin
          dec.cmd    = ddpi_pkg::CMD_FWD;
          dec.spd    = ddpi_pkg::SPD_WANDER_BACKOFF;
          dec.status = ddpi_pkg::STATUS_REAR;
        end else begin
          dec.cmd = ddpi_pkg::CMD_FWD;
          dec.spd = ddpi_pkg::SPD_WANDER_FWD;
        end
      end
      ddpi_pkg::MODE_TRACK: begin
        if (front_hit) begin
          dec.status = ddpi_pkg::STATUS_FRONT;
        end else if (sample.rear_obstacle) begin
          dec.status = ddpi_pkg::STATUS_REAR;
        end else if (no_target) begin
          dec.cmd = ddpi_pkg::CMD_STOP;
        end else if (in_window) begin
          dec.cmd = ddpi_pkg::CMD_FWD;
          dec.spd = ddpi_pkg::SPD_TRACK_FWD;
        end else if (tx_ext > half) begin
          dec.cmd = ddpi_pkg::CMD_RIGHT;
          dec.spd = ddpi_pkg::SPD_TRACK_TURN;
        end else begin
          dec.cmd = ddpi_pkg::CMD_LEFT;
          dec.spd = ddpi_pkg::SPD_TRACK_TURN;
        end
      end
      default: ;
    endcase
  end

  // Wheel setpoints and speed errors.
  logic signed [ddpi_pkg::ERR_W-1:0] spd_pos, spd_neg, set_left, set_right;
  logic signed [ddpi_pkg::ERR_W-1:0] err_left_next, err_right_next;

  always_comb begin
    spd_pos = signed'(ddpi_pkg::ERR_W'(dec.spd));
    spd_neg = -spd_pos;
    unique case (dec.cmd)
      ddpi_pkg::CMD_BACK: begin
        set_left  = spd_neg;
        set_right = spd_neg;
      end
      ddpi_pkg::CMD_RIGHT: begin
        set_left  = spd_pos;
        set_right = spd_neg;
      end
      ddpi_pkg::CMD_LEFT: begin
        set_left  = spd_neg;
        set_right = spd_pos;
      end
      default: begin
        set_left  = spd_pos;
        set_right = spd_pos;
      end
    endcase
    err_left_next  = set_left - ddpi_pkg::ERR_W'(sample.speed_left);
    err_right_next = set_right - ddpi_pkg::ERR_W'(sample.speed_right);
  end

  ddpi_pkg::decision_t                dec_b, dec_c, dec_d;
  logic signed [ddpi_pkg::ERR_W-1:0]  err_left, err_right;
  logic signed [ddpi_pkg::PROD_W-1:0] p_left_c, p_right_c, i_left_c, i_right_c;
  logic signed [ddpi_pkg::PROD_W-1:0] p_left_d, p_right_d;
  logic signed [ddpi_pkg::INTEG_W-1:0] integral_left, integral_right;
  logic signed [ddpi_pkg::GAIN_W:0]   kp_s, kil_s, kir_s;

  assign kp_s  = signed'({1'b0, kp_q16});
  assign kil_s = signed'({1'b0, ki_left_q16});
  assign kir_s = signed'({1'b0, ki_right_q16});

  always_ff @(posedge clk) begin
    if (adv_b) begin
      dec_b     <= dec;
      err_left  <= err_left_next;
      err_right <= err_right_next;
    end
    if (adv_c) begin
      dec_c     <= dec_b;
      p_left_c  <= kp_s * err_left;
      p_right_c <= kp_s * err_right;
      i_left_c  <= kil_s * err_left;
      i_right_c <= kir_s * err_right;
    end
    if (adv_d) begin
      dec_d     <= dec_c;
      p_left_d  <= p_left_c;
      p_right_d <= p_right_c;
    end
    if (adv_o) begin
      result.duty_left       <= ddpi_pkg::duty_of(p_left_d, integral_left);
      result.duty_right      <= ddpi_pkg::duty_of(p_right_d, integral_right);
      result.obstacle_status <= dec_d.status;
      result.drive_command   <= dec_d.cmd;
      result.drive_speed     <= dec_d.spd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_left  <= '0;
      integral_right <= '0;
    end else if (adv_d) begin
      integral_left  <= ddpi_pkg::integ_add(integral_left, i_left_c);
      integral_right <= ddpi_pkg::integ_add(integral_right, i_right_c);
    end
  end

  `ASSERT_NEXT(a_integ_hold, clk, rst, !adv_d,
    $stable(integral_left) && $stable(integral_right),
    "integral changed without a stage transfer")
  `ASSERT_IMPL(a_stop_on_obstacle, clk, rst,
    result.valid && result.obstacle_status != ddpi_pkg::STATUS_NONE &&
    drive_mode != ddpi_pkg::MODE_WANDER,
    result.drive_command == ddpi_pkg::CMD_STOP && result.drive_speed == '0,
    "obstacle did not force a stop")
  `ASSERT_AFTER_RESET(a_empty_after_reset, clk, rst,
    !result.valid && !valid_b && !valid_c && !valid_d,
    "pipeline not empty after reset")

endmodule
